// ----- sv/lbt_pkg.sv -----
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared types and constants of the led blink and one-shot timer bank.
// ----------------------------------------------------------------------------
package lbt_pkg;

  localparam int CNT_W        = 16;
  localparam int MODE_W       = 2;
  localparam int CHANNEL_W    = 2;
  localparam int TIMER_IDX_W  = 3;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_CHANNELS = 4;
  localparam int REG_COUNT    = 2 * CFG_CHANNELS;
  localparam int EXPIRED_W    = 8;
  localparam int PHASE_W      = 4;

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

  // reload values after reset, per channel
  localparam logic [CNT_W-1:0] ON_TICKS_RST [CFG_CHANNELS] =
    '{16'd500, 16'd1000, 16'd3000, 16'd4000};
  localparam logic [CNT_W-1:0] OFF_TICKS_RST [CFG_CHANNELS] =
    '{16'd500, 16'd1000, 16'd1000, 16'd4000};

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [CHANNEL_W-1:0]   channel;
    logic                   led_request;
    logic [TIMER_IDX_W-1:0] timer_index;
    logic [CNT_W-1:0]       timer_value;
  } item_t;

endpackage

// ----- sv/lbt_ifs.sv -----
// ----------------------------------------------------------------------------
// lbt channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface lbt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lbt_pkg::MODE_W-1:0]           mode;
  logic [lbt_pkg::CHANNEL_W-1:0]        channel;
  logic                                 led_request;
  logic [lbt_pkg::TIMER_IDX_W-1:0]      timer_index;
  logic [lbt_pkg::CNT_W-1:0]            timer_value;

  modport source (output valid, mode, channel, led_request, timer_index, timer_value,
                  input ready);
  modport sink (input valid, mode, channel, led_request, timer_index, timer_value,
                output ready);
endinterface

interface lbt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            led_drive;
  logic [lbt_pkg::EXPIRED_W-1:0]   expired_mask;
  logic [lbt_pkg::PHASE_W-1:0]     phase_mask;

  modport source (output valid, led_drive, expired_mask, phase_mask, input ready);
  modport sink (input valid, led_drive, expired_mask, phase_mask, output ready);
endinterface

interface lbt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbt_pkg::CFG_IDX_W-1:0]   index;
  logic [lbt_pkg::CNT_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/lbt_cfg.sv -----
// ----------------------------------------------------------------------------
// lbt_cfg
// On and off reload registers of the blink channels.
// ----------------------------------------------------------------------------
module lbt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [lbt_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [lbt_pkg::CNT_W-1:0]           wr_data,
  output lbt_pkg::cnt_t                       on_ticks  [lbt_pkg::CFG_CHANNELS],
  output lbt_pkg::cnt_t                       off_ticks [lbt_pkg::CFG_CHANNELS]
);

  lbt_pkg::cnt_t on_ticks_r  [lbt_pkg::CFG_CHANNELS];
  lbt_pkg::cnt_t off_ticks_r [lbt_pkg::CFG_CHANNELS];
  logic          in_range;

  assign in_range = (wr_index < lbt_pkg::CFG_IDX_W'(lbt_pkg::REG_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < lbt_pkg::CFG_CHANNELS; c++) begin
        on_ticks_r[c]  <= lbt_pkg::ON_TICKS_RST[c];
        off_ticks_r[c] <= lbt_pkg::OFF_TICKS_RST[c];
      end
    end else if (wr_en && in_range) begin
      for (int c = 0; c < lbt_pkg::CFG_CHANNELS; c++) begin
        // even index is the on reload, odd the off reload
        if (wr_index[2:1] == 2'(c)) begin
          if (wr_index[0]) begin
            off_ticks_r[c] <= wr_data;
          end else begin
            on_ticks_r[c] <= wr_data;
          end
        end
      end
    end
  end

  assign on_ticks  = on_ticks_r;
  assign off_ticks = off_ticks_r;

endmodule

// ----- sv/lbt_blink.sv -----
// ----------------------------------------------------------------------------
// lbt_blink
// Blink channels: phase and down-counter per channel, blink request answer.
// ----------------------------------------------------------------------------
module lbt_blink #(
  parameter int BLINK_CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  lbt_pkg::item_t       item,
  input  lbt_pkg::cnt_t        on_ticks  [lbt_pkg::CFG_CHANNELS],
  input  lbt_pkg::cnt_t        off_ticks [lbt_pkg::CFG_CHANNELS],
  output logic [BLINK_CHANNELS-1:0] phase_nxt_o,
  output logic                 led_drive
);

  logic [BLINK_CHANNELS-1:0] phase_r;
  logic [BLINK_CHANNELS-1:0] phase_nxt;
  lbt_pkg::cnt_t             count_r   [BLINK_CHANNELS];
  lbt_pkg::cnt_t             count_nxt [BLINK_CHANNELS];
  logic [BLINK_CHANNELS-1:0] drive_hit;

  always_comb begin
    for (int c = 0; c < BLINK_CHANNELS; c++) begin
      phase_nxt[c] = phase_r[c];
      count_nxt[c] = count_r[c];
      drive_hit[c] = 1'b0;
      if (item.mode == lbt_pkg::MODE_TICK) begin
        if (count_r[c] == '0) begin
          count_nxt[c] = phase_r[c] ? off_ticks[c] : on_ticks[c];
          phase_nxt[c] = ~phase_r[c];
        end else begin
          count_nxt[c] = count_r[c] - lbt_pkg::CNT_W'(1);
        end
      end else if (item.mode == lbt_pkg::MODE_BLINK &&
                   item.channel == lbt_pkg::CHANNEL_W'(c)) begin
        phase_nxt[c] = item.led_request;
        // led is driven inverted while the channel sits at zero
        drive_hit[c] = (count_r[c] == '0) ? ~item.led_request : item.led_request;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int c = 0; c < BLINK_CHANNELS; c++) begin
        count_r[c] <= '0;
      end
    end else if (advance) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  assign phase_nxt_o = phase_nxt;
  assign led_drive   = |drive_hit;

endmodule

// ----- sv/lbt_oneshot.sv -----
// ----------------------------------------------------------------------------
// lbt_oneshot
// Bank of one-shot down-counters that stop at zero.
// ----------------------------------------------------------------------------
module lbt_oneshot #(
  parameter int ONESHOT_TIMERS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  lbt_pkg::item_t            item,
  output logic [ONESHOT_TIMERS-1:0] expired_nxt
);

  lbt_pkg::cnt_t count_r   [ONESHOT_TIMERS];
  lbt_pkg::cnt_t count_nxt [ONESHOT_TIMERS];

  always_comb begin
    for (int t = 0; t < ONESHOT_TIMERS; t++) begin
      count_nxt[t] = count_r[t];
      if (item.mode == lbt_pkg::MODE_TICK) begin
        if (count_r[t] != '0) begin
          count_nxt[t] = count_r[t] - lbt_pkg::CNT_W'(1);
        end
      end else if (item.mode == lbt_pkg::MODE_LOAD && int'(item.timer_index) == t) begin
        count_nxt[t] = item.timer_value;
      end
      expired_nxt[t] = (count_nxt[t] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < ONESHOT_TIMERS; t++) begin
        count_r[t] <= '0;
      end
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/led_blink_and_oneshot_timer_bank.sv -----
// ----------------------------------------------------------------------------
// led_blink_and_oneshot_timer_bank
// Blink channels and one-shot counters driven by tick, load and blink items.
// ----------------------------------------------------------------------------
// Each input beat is captured in an input register and, when the held item
// moves on, all blink channels and one-shot counters update together in a
// single combinational pass that writes the result register. One result beat
// comes out per input beat, and a new item is taken in every cycle while the
// input register is empty or the held item moves on to the result register.
// The input and result registers hold two beats between them: while a result
// waits, one more beat is taken, and then the input stalls for as long as the
// result side keeps out_ch.ready low. Register writes are taken at any time
// (cfg_ch.ready is always high) and are meant to arrive while idle.
module led_blink_and_oneshot_timer_bank #(
  parameter int BLINK_CHANNELS = 4,
  parameter int ONESHOT_TIMERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  lbt_in_if.sink    in_ch,
  lbt_out_if.source out_ch,
  lbt_cfg_if.sink   cfg_ch
);

  lbt_pkg::item_t              item_r;
  logic                        item_valid_r;
  logic                        advance;
  lbt_pkg::cnt_t               on_ticks  [lbt_pkg::CFG_CHANNELS];
  lbt_pkg::cnt_t               off_ticks [lbt_pkg::CFG_CHANNELS];
  logic [BLINK_CHANNELS-1:0]   phase_nxt;
  logic [ONESHOT_TIMERS-1:0]   expired_nxt;
  logic                        led_drive_nxt;
  logic [lbt_pkg::EXPIRED_W-1:0] expired_mask_nxt;
  logic [lbt_pkg::PHASE_W-1:0]   phase_mask_nxt;
  logic                        out_valid_r;
  logic                        led_drive_r;
  logic [lbt_pkg::EXPIRED_W-1:0] expired_mask_r;
  logic [lbt_pkg::PHASE_W-1:0]   phase_mask_r;

  // the held item moves on when the result register is empty or draining
  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.mode        <= in_ch.mode;
      item_r.channel     <= in_ch.channel;
      item_r.led_request <= in_ch.led_request;
      item_r.timer_index <= in_ch.timer_index;
      item_r.timer_value <= in_ch.timer_value;
    end
  end

  lbt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_ch.valid),
    .wr_index  (cfg_ch.index),
    .wr_data   (cfg_ch.data),
    .on_ticks  (on_ticks),
    .off_ticks (off_ticks)
  );

  lbt_blink #(
    .BLINK_CHANNELS (BLINK_CHANNELS)
  ) u_blink (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (item_r),
    .on_ticks    (on_ticks),
    .off_ticks   (off_ticks),
    .phase_nxt_o (phase_nxt),
    .led_drive   (led_drive_nxt)
  );

  lbt_oneshot #(
    .ONESHOT_TIMERS (ONESHOT_TIMERS)
  ) u_oneshot (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (item_r),
    .expired_nxt (expired_nxt)
  );

  // masks carry zeros for counters and channels that do not exist
  for (genvar t = 0; t < lbt_pkg::EXPIRED_W; t++) begin : g_exp
    if (t < ONESHOT_TIMERS) begin : g_on
      assign expired_mask_nxt[t] = expired_nxt[t];
    end else begin : g_off
      assign expired_mask_nxt[t] = 1'b0;
    end
  end

  for (genvar c = 0; c < lbt_pkg::PHASE_W; c++) begin : g_ph
    if (c < BLINK_CHANNELS) begin : g_on
      assign phase_mask_nxt[c] = phase_nxt[c];
    end else begin : g_off
      assign phase_mask_nxt[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_drive_r    <= led_drive_nxt;
      expired_mask_r <= expired_mask_nxt;
      phase_mask_r   <= phase_mask_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_drive    = led_drive_r;
  assign out_ch.expired_mask = expired_mask_r;
  assign out_ch.phase_mask   = phase_mask_r;

endmodule

// ----- tb/tb_led_blink_and_oneshot_timer_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_blink_and_oneshot_timer_bank
// Checks every result beat of the blink and one-shot timer bank against a
// cycle-free model of its channels and counters. A few directed items cover
// reset state, loads, blink requests and zero reloads. Random traffic follows
// under changing reload settings with random gaps on both sides. The run
// ends with the largest reload values.
// ----------------------------------------------------------------------------
module tb_led_blink_and_oneshot_timer_bank;
  import lbt_pkg::*;

  localparam int BLINK_CHANNELS = 4;
  localparam int ONESHOT_TIMERS = 8;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_ITEMS    = 52;
  localparam int CYCLE_LIMIT    = 500000;

  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_TICKS_0, REG_OFF_TICKS_0,
    REG_ON_TICKS_1, REG_OFF_TICKS_1,
    REG_ON_TICKS_2, REG_OFF_TICKS_2,
    REG_ON_TICKS_3, REG_OFF_TICKS_3
  } reload_reg_e;

  typedef struct packed {
    logic                 led_drive;
    logic [EXPIRED_W-1:0] expired_mask;
    logic [PHASE_W-1:0]   phase_mask;
  } bank_result_t;

  logic clk;
  logic rst_n;

  lbt_in_if  in_ch();
  lbt_out_if out_ch();
  lbt_cfg_if cfg_ch();

  led_blink_and_oneshot_timer_bank #(
    .BLINK_CHANNELS(BLINK_CHANNELS),
    .ONESHOT_TIMERS(ONESHOT_TIMERS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // model of the bank
  cnt_t on_ticks   [CFG_CHANNELS];
  cnt_t off_ticks  [CFG_CHANNELS];
  logic blink_on   [BLINK_CHANNELS];
  cnt_t blink_cnt  [BLINK_CHANNELS];
  cnt_t oneshot_cnt[ONESHOT_TIMERS];

  bank_result_t expected_beats[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  in_gaps_on     = 1'b1;
  bit  out_stalls_on  = 1'b1;
  bit  in_held        = 1'b0;
  int  next_in_gap    = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic advance_bank_state(input item_t it, output bank_result_t res);
    res = '0;
    case (it.mode)
      MODE_TICK: begin
        for (int c = 0; c < BLINK_CHANNELS && c < CFG_CHANNELS; c++) begin
          if (blink_cnt[c] == '0) begin
            blink_cnt[c] = blink_on[c] ? off_ticks[c] : on_ticks[c];
            blink_on[c]  = ~blink_on[c];
          end else begin
            blink_cnt[c] = blink_cnt[c] - 1'b1;
          end
        end
        for (int t = 0; t < ONESHOT_TIMERS; t++)
          if (oneshot_cnt[t] != '0) oneshot_cnt[t] = oneshot_cnt[t] - 1'b1;
      end
      MODE_LOAD: begin
        if (it.timer_index < ONESHOT_TIMERS) oneshot_cnt[it.timer_index] = it.timer_value;
      end
      MODE_BLINK: begin
        if (it.channel < BLINK_CHANNELS) begin
          blink_on[it.channel] = it.led_request;
          // idle counter answers with the request inverted
          res.led_drive = (blink_cnt[it.channel] == '0) ? ~it.led_request : it.led_request;
        end
      end
      default: begin
      end
    endcase
    for (int t = 0; t < ONESHOT_TIMERS && t < EXPIRED_W; t++)
      res.expired_mask[t] = (oneshot_cnt[t] == '0);
    for (int c = 0; c < BLINK_CHANNELS && c < PHASE_W; c++)
      res.phase_mask[c] = blink_on[c];
  endtask

  function automatic item_t make_item(input logic [MODE_W-1:0] mode,
                                      input logic [CHANNEL_W-1:0] channel,
                                      input logic led_request,
                                      input logic [TIMER_IDX_W-1:0] timer_index,
                                      input cnt_t timer_value);
    item_t it;
    it.mode        = mode;
    it.channel     = channel;
    it.led_request = led_request;
    it.timer_index = timer_index;
    it.timer_value = timer_value;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it   = make_item(MODE_TICK, CHANNEL_W'($urandom), 1'($urandom),
                     TIMER_IDX_W'($urandom), CNT_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 50)      it.mode = MODE_TICK;
    else if (pick < 75) it.mode = MODE_LOAD;
    else if (pick < 95) it.mode = MODE_BLINK;
    else                it.mode = MODE_SPARE;
    // short loads so counters expire within a phase
    if ($urandom_range(0, 9) < 7) it.timer_value = CNT_W'($urandom_range(0, 30));
    return it;
  endfunction

  function automatic cnt_t rand_reload();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick < 12) return CNT_W'($urandom_range(1, 12));
    return CNT_W'($urandom_range(13, 200));
  endfunction

  task automatic send_timer_item(input item_t it);
    bank_result_t res;
    int           gap;
    if (!in_held) repeat (next_in_gap) @(posedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.channel     <= it.channel;
    in_ch.led_request <= it.led_request;
    in_ch.timer_index <= it.timer_index;
    in_ch.timer_value <= it.timer_value;
    do @(posedge clk); while (!in_ch.ready);
    advance_bank_state(it, res);
    expected_beats.push_back(res);
    gap = in_gaps_on ? $urandom_range(0, 11) : 0;
    // zero gap keeps valid up for the next beat
    if (gap == 0) begin
      in_held = 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    next_in_gap = gap;
  endtask

  task automatic wait_bank_idle();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all eight reloads, then two writes past the register file, back to back
  task automatic program_reloads(input cnt_t reload [REG_COUNT]);
    logic [CFG_IDX_W-1:0] idx;
    cnt_t                 value;
    for (int i = 0; i < REG_COUNT + 2; i++) begin
      if (i < REG_COUNT) begin
        idx   = CFG_IDX_W'(i);
        value = reload[i];
      end else if (i == REG_COUNT) begin
        idx   = CFG_IDX_W'(REG_COUNT);
        value = CNT_W'($urandom);
      end else begin
        idx   = CFG_IDX_W'($urandom_range(REG_COUNT, CFG_IDX_LAST));
        value = CNT_W'($urandom);
      end
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= value;
      do @(posedge clk); while (!cfg_ch.ready);
      if (idx < REG_COUNT) begin
        if (idx[0]) off_ticks[idx >> 1] = value;
        else        on_ticks[idx >> 1]  = value;
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_timer_item(make_item(MODE_SPARE, 2'd3, 1'b1, 3'd7, 16'hFFFF));
    send_timer_item(make_item(MODE_BLINK, 2'd0, 1'b1, 3'd0, 16'h0000));
    send_timer_item(make_item(MODE_BLINK, 2'd3, 1'b0, 3'd5, 16'h5A5A));
  endtask

  task automatic test_oneshot_loads();
    send_timer_item(make_item(MODE_LOAD, 2'd1, 1'b0, 3'd0, 16'hFFFF));
    send_timer_item(make_item(MODE_LOAD, 2'd2, 1'b1, 3'd7, 16'h0001));
    send_timer_item(make_item(MODE_LOAD, 2'd0, 1'b0, 3'd3, 16'h0000));
    send_timer_item(make_item(MODE_LOAD, 2'd3, 1'b1, 3'd5, 16'h0002));
    send_timer_item(make_item(MODE_TICK, 2'd0, 1'b0, 3'd0, 16'h0000));
    send_timer_item(make_item(MODE_TICK, 2'd3, 1'b1, 3'd7, 16'hFFFF));
  endtask

  task automatic test_blink_channels();
    for (int c = 0; c < BLINK_CHANNELS; c++)
      for (int r = 0; r < 2; r++)
        send_timer_item(make_item(MODE_BLINK, CHANNEL_W'(c), 1'(r), 3'd0, 16'h0000));
    send_timer_item(make_item(MODE_TICK, 2'd0, 1'b0, 3'd0, 16'h0000));
    send_timer_item(make_item(MODE_BLINK, 2'd2, 1'b1, 3'd0, 16'h0000));
  endtask

  task automatic test_zero_reload();
    cnt_t reload [REG_COUNT];
    wait_bank_idle();
    for (int i = REG_ON_TICKS_0; i <= REG_OFF_TICKS_3; i++) reload[i] = '0;
    program_reloads(reload);
    for (int n = 0; n < 3; n++) begin
      send_timer_item(make_item(MODE_TICK, 2'd1, 1'b1, 3'd2, 16'h0003));
      send_timer_item(make_item(MODE_BLINK, CHANNEL_W'(n), 1'b1, 3'd0, 16'h0000));
    end
  endtask

  task automatic test_random_traffic();
    cnt_t reload [REG_COUNT];
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_bank_idle();
      for (int i = REG_ON_TICKS_0; i <= REG_OFF_TICKS_3; i++) reload[i] = rand_reload();
      program_reloads(reload);
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_timer_item(rand_item());
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_max_reload();
    cnt_t reload [REG_COUNT];
    bit   loaded;
    int   n;
    wait_bank_idle();
    for (int i = REG_ON_TICKS_0; i <= REG_OFF_TICKS_3; i++) reload[i] = 16'hFFFF;
    program_reloads(reload);
    in_gaps_on = 1'b0;
    loaded     = 1'b0;
    n          = 0;
    // tick until every channel has taken the full reload
    while (!loaded && n < 400) begin
      send_timer_item(make_item(MODE_TICK, CHANNEL_W'($urandom), 1'($urandom),
                                TIMER_IDX_W'($urandom), CNT_W'($urandom)));
      loaded = 1'b1;
      for (int c = 0; c < BLINK_CHANNELS; c++)
        if (blink_cnt[c] < 16'hFF00) loaded = 1'b0;
      n++;
    end
    in_gaps_on = 1'b1;
    for (int c = 0; c < BLINK_CHANNELS; c++)
      send_timer_item(make_item(MODE_BLINK, CHANNEL_W'(c), 1'($urandom), 3'd0, 16'h0000));
    send_timer_item(make_item(MODE_LOAD, 2'd0, 1'b0, 3'd6, 16'hFFFF));
    send_timer_item(make_item(MODE_TICK, 2'd0, 1'b0, 3'd0, 16'h0000));
  endtask

  // result side: random stalls, every beat checked against the oldest prediction
  initial begin
    bank_result_t exp_res;
    int           stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_beats.size() == 0) begin
        flag_mismatch("result beat with no prediction pending");
      end else begin
        exp_res = expected_beats.pop_front();
        if (out_ch.led_drive !== exp_res.led_drive)
          flag_mismatch($sformatf("led_drive got %b want %b",
                                  out_ch.led_drive, exp_res.led_drive));
        if (out_ch.expired_mask !== exp_res.expired_mask)
          flag_mismatch($sformatf("expired_mask got %h want %h",
                                  out_ch.expired_mask, exp_res.expired_mask));
        if (out_ch.phase_mask !== exp_res.phase_mask)
          flag_mismatch($sformatf("phase_mask got %h want %h",
                                  out_ch.phase_mask, exp_res.phase_mask));
      end
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.channel      = '0;
    in_ch.led_request  = 1'b0;
    in_ch.timer_index  = '0;
    in_ch.timer_value  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    for (int c = 0; c < CFG_CHANNELS; c++) begin
      on_ticks[c]  = ON_TICKS_RST[c];
      off_ticks[c] = OFF_TICKS_RST[c];
    end
    for (int c = 0; c < BLINK_CHANNELS; c++) begin
      blink_on[c]  = 1'b0;
      blink_cnt[c] = '0;
    end
    for (int t = 0; t < ONESHOT_TIMERS; t++) oneshot_cnt[t] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_oneshot_loads();
    test_blink_channels();
    test_zero_reload();
    test_random_traffic();
    test_max_reload();

    wait_bank_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
